[hw/rtl/dsi_pkg.sv]
// ----------------------------------------------------------------------------
// dsi_pkg
// Shared widths, types, register indexes and the saturating clip function
// for the damped spring impulse pipeline.
// ----------------------------------------------------------------------------
package dsi_pkg;

    // word format
    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int CFG_W       = WORD_W - 1;
    localparam int CFG_IDX_W   = 2;

    // derived widths
    localparam int PROD_W      = 2 * WORD_W;
    localparam int WIDE_W      = 2 * WORD_W + 4;
    localparam int UNIT_W      = FRAC_W + 2;
    localparam int DIV_N       = WORD_W + FRAC_W;
    localparam int GU_W        = WORD_W + UNIT_W;

    // pipelined unit depths
    localparam int SQRT_STAGES = WORD_W;
    localparam int DIV_STAGES  = DIV_N;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [UNIT_W-1:0] t_unit;
    typedef logic signed [GU_W-1:0]   t_gu;
    typedef logic [CFG_W-1:0]         t_cfg;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS = CFG_IDX_W'(0),
        CFG_DAMPING   = CFG_IDX_W'(1),
        CFG_REST      = CFG_IDX_W'(2)
    } t_cfg_idx;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        t_word val;
        logic  sat;
    } t_clip;

    // side data riding beside the square root
    typedef struct packed {
        logic  pa;
        logic  pb;
        logic  sat;
        logic  degen;
        t_word dx;
        t_word dy;
        t_word g;
    } t_side1;

    // side data riding beside the unit vector divide
    typedef struct packed {
        logic              pa;
        logic              pb;
        logic              sat;
        logic              degen;
        logic              sx;
        logic              sy;
        t_word             g;
        t_word             stretch;
        logic [WORD_W-1:0] len;
    } t_side2;

    // side data riding beside the damping divide
    typedef struct packed {
        logic pa;
        logic pb;
        logic sat;
        logic degen;
        logic sgx;
        logic sgy;
        t_gu  sux;
        t_gu  suy;
    } t_side3;

    // clip a wide signed value to the word range
    function automatic t_clip clip_word(input t_wide v);
        t_clip c;
        if (v > t_wide'(WORD_MAX)) begin
            c.val = WORD_MAX;
            c.sat = 1'b1;
        end else if (v < t_wide'(WORD_MIN)) begin
            c.val = WORD_MIN;
            c.sat = 1'b1;
        end else begin
            c.val = v[WORD_W-1:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

[hw/rtl/dsi_sqrt.sv]
// ----------------------------------------------------------------------------
// dsi_sqrt
// Pipelined integer square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module dsi_sqrt
    import dsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PROD_W-1:0] i_radicand,
    output logic [WORD_W-1:0] o_root
);

    logic [PROD_W-1:0] r_rem  [SQRT_STAGES];
    logic [WORD_W-1:0] r_root [SQRT_STAGES];
    logic [PROD_W-1:0] p_rem  [SQRT_STAGES];
    logic [WORD_W-1:0] p_root [SQRT_STAGES];
    logic [PROD_W-1:0] n_rem  [SQRT_STAGES];
    logic [WORD_W-1:0] n_root [SQRT_STAGES];
    logic [PROD_W+1:0] trial  [SQRT_STAGES];

    // stage inputs
    always_comb begin
        p_rem[0]  = i_radicand;
        p_root[0] = '0;
        for (int k = 1; k < SQRT_STAGES; k++) begin
            p_rem[k]  = r_rem[k-1];
            p_root[k] = r_root[k-1];
        end
    end

    // trial subtract of (2*root + bit) * bit per stage
    always_comb begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            trial[k] = ((PROD_W+2)'(p_root[k]) << (SQRT_STAGES - k))
                     + ((PROD_W+2)'(1) << (2 * (SQRT_STAGES - 1 - k)));
            if ({2'b00, p_rem[k]} >= trial[k]) begin
                n_rem[k]  = PROD_W'({2'b00, p_rem[k]} - trial[k]);
                n_root[k] = p_root[k] | (WORD_W'(1) << (SQRT_STAGES - 1 - k));
            end else begin
                n_rem[k]  = p_rem[k];
                n_root[k] = p_root[k];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

[hw/rtl/dsi_div.sv]
// ----------------------------------------------------------------------------
// dsi_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module dsi_div
    import dsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_N-1:0]  i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic [DIV_N-1:0]  o_quotient
);

    logic [WORD_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_N-1:0]  r_quo [DIV_STAGES];
    logic [DIV_N-1:0]  r_dvd [DIV_STAGES];
    logic [WORD_W-1:0] r_dsr [DIV_STAGES];
    logic [WORD_W-1:0] p_rem [DIV_STAGES];
    logic [DIV_N-1:0]  p_quo [DIV_STAGES];
    logic [DIV_N-1:0]  p_dvd [DIV_STAGES];
    logic [WORD_W-1:0] p_dsr [DIV_STAGES];
    logic [WORD_W-1:0] n_rem [DIV_STAGES];
    logic [DIV_N-1:0]  n_quo [DIV_STAGES];
    logic [WORD_W:0]   rem_sh [DIV_STAGES];

    // stage inputs
    always_comb begin
        p_rem[0] = '0;
        p_quo[0] = '0;
        p_dvd[0] = i_dividend;
        p_dsr[0] = i_divisor;
        for (int k = 1; k < DIV_STAGES; k++) begin
            p_rem[k] = r_rem[k-1];
            p_quo[k] = r_quo[k-1];
            p_dvd[k] = r_dvd[k-1];
            p_dsr[k] = r_dsr[k-1];
        end
    end

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            rem_sh[k] = {p_rem[k], p_dvd[k][DIV_N-1-k]};
            if (rem_sh[k] >= {1'b0, p_dsr[k]}) begin
                n_rem[k] = WORD_W'(rem_sh[k] - {1'b0, p_dsr[k]});
                n_quo[k] = p_quo[k] | (DIV_N'(1) << (DIV_N - 1 - k));
            end else begin
                n_rem[k] = rem_sh[k][WORD_W-1:0];
                n_quo[k] = p_quo[k];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dvd[k] <= p_dvd[k];
                r_dsr[k] <= p_dsr[k];
            end
        end
    end

    assign o_quotient = r_quo[DIV_STAGES-1];

endmodule

[hw/rtl/damped_spring_impulse_unit.sv]
// Depth: 139 register stages from the input to o_valid.
// Throughput: one item per cycle unless a stalled result is waiting; the square root
// and all four dividers resolve one bit per stage, which sets the depth (32 root
// stages, two 48-stage divides). A stalled result holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and the three config registers.
// ----------------------------------------------------------------------------
// damped_spring_impulse_unit
// Two-body damped spring impulse in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module damped_spring_impulse_unit
    import dsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [WORD_W-1:0] i_anchor_a_x,
    input  logic signed [WORD_W-1:0] i_anchor_a_y,
    input  logic signed [WORD_W-1:0] i_anchor_b_x,
    input  logic signed [WORD_W-1:0] i_anchor_b_y,
    input  logic signed [WORD_W-1:0] i_velocity_a_x,
    input  logic signed [WORD_W-1:0] i_velocity_a_y,
    input  logic signed [WORD_W-1:0] i_velocity_b_x,
    input  logic signed [WORD_W-1:0] i_velocity_b_y,
    input  logic                 i_body_a_present,
    input  logic                 i_body_b_present,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [WORD_W-1:0] o_impulse_a_x,
    output logic signed [WORD_W-1:0] o_impulse_a_y,
    output logic signed [WORD_W-1:0] o_impulse_b_x,
    output logic signed [WORD_W-1:0] o_impulse_b_y,
    output logic                 o_apply_a,
    output logic                 o_apply_b,
    output logic                 o_degenerate,
    output logic                 o_saturated,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic en;

    // configuration registers
    t_cfg r_stiff, r_damp, r_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= '0;
            r_damp  <= '0;
            r_rest  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STIFFNESS: r_stiff <= i_cfg_data;
                CFG_DAMPING:   r_damp  <= i_cfg_data;
                CFG_REST:      r_rest  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold everything while a result waits
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // ------------------------------------------------------------ stage 1
    // separation and relative velocity
    t_word n1_vax, n1_vay, n1_vbx, n1_vby;
    t_clip c1_dx, c1_dy, c1_vx, c1_vy;
    logic  r1_valid, r1_pa, r1_pb, r1_sat;
    t_word r1_dx, r1_dy, r1_vx, r1_vy;

    always_comb begin
        n1_vax = i_body_a_present ? i_velocity_a_x : t_word'(0);
        n1_vay = i_body_a_present ? i_velocity_a_y : t_word'(0);
        n1_vbx = i_body_b_present ? i_velocity_b_x : t_word'(0);
        n1_vby = i_body_b_present ? i_velocity_b_y : t_word'(0);
        c1_dx  = clip_word(t_wide'(i_anchor_b_x) - t_wide'(i_anchor_a_x));
        c1_dy  = clip_word(t_wide'(i_anchor_b_y) - t_wide'(i_anchor_a_y));
        c1_vx  = clip_word(t_wide'(n1_vbx) - t_wide'(n1_vax));
        c1_vy  = clip_word(t_wide'(n1_vby) - t_wide'(n1_vay));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pa  <= i_body_a_present;
            r1_pb  <= i_body_b_present;
            r1_dx  <= c1_dx.val;
            r1_dy  <= c1_dy.val;
            r1_vx  <= c1_vx.val;
            r1_vy  <= c1_vy.val;
            r1_sat <= c1_dx.sat | c1_dy.sat | c1_vx.sat | c1_vy.sat;
        end
    end

    // ------------------------------------------------------------ stage 2
    // squares and velocity products
    t_prod n2_dxx, n2_dyy, n2_pvx, n2_pvy;
    logic  r2_valid, r2_pa, r2_pb, r2_sat, r2_degen;
    t_word r2_dx, r2_dy;
    t_prod r2_dxx, r2_dyy, r2_pvx, r2_pvy;

    always_comb begin
        n2_dxx = r1_dx * r1_dx;
        n2_dyy = r1_dy * r1_dy;
        n2_pvx = r1_vx * r1_dx;
        n2_pvy = r1_vy * r1_dy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pa    <= r1_pa;
            r2_pb    <= r1_pb;
            r2_sat   <= r1_sat;
            r2_degen <= (r1_dx == t_word'(0)) && (r1_dy == t_word'(0));
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
            r2_dxx   <= n2_dxx;
            r2_dyy   <= n2_dyy;
            r2_pvx   <= n2_pvx;
            r2_pvy   <= n2_pvy;
        end
    end

    // ------------------------------------------------------------ stage 3
    // squared length and dot product
    t_clip c3_dot;
    logic  r3_valid, r3_pa, r3_pb, r3_sat, r3_degen;
    t_word r3_dx, r3_dy, r3_dot;
    logic [PROD_W-1:0] r3_sq;

    assign c3_dot = clip_word(t_wide'(r2_pvx >>> FRAC_W) + t_wide'(r2_pvy >>> FRAC_W));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_pa    <= r2_pa;
            r3_pb    <= r2_pb;
            r3_sat   <= r2_sat | c3_dot.sat;
            r3_degen <= r2_degen;
            r3_dx    <= r2_dx;
            r3_dy    <= r2_dy;
            r3_dot   <= c3_dot.val;
            r3_sq    <= $unsigned(r2_dxx) + $unsigned(r2_dyy);
        end
    end

    // ------------------------------------------------------------ stage 4
    // damping gain times dot
    t_prod n4_pdamp;
    logic  r4_valid, r4_pa, r4_pb, r4_sat, r4_degen;
    t_word r4_dx, r4_dy;
    t_prod r4_pdamp;
    logic [PROD_W-1:0] r4_sq;

    assign n4_pdamp = $signed({1'b0, r_damp}) * r3_dot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_pa    <= r3_pa;
            r4_pb    <= r3_pb;
            r4_sat   <= r3_sat;
            r4_degen <= r3_degen;
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;
            r4_pdamp <= n4_pdamp;
            r4_sq    <= r3_sq;
        end
    end

    // ------------------------------------------------------------ stage 5
    // damping term g
    t_clip c5_g;
    logic  r5_valid;
    t_side1 r5_side;
    logic [PROD_W-1:0] r5_sq;

    assign c5_g = clip_word(t_wide'(r4_pdamp >>> FRAC_W));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side.pa    <= r4_pa;
            r5_side.pb    <= r4_pb;
            r5_side.sat   <= r4_sat | c5_g.sat;
            r5_side.degen <= r4_degen;
            r5_side.dx    <= r4_dx;
            r5_side.dy    <= r4_dy;
            r5_side.g     <= c5_g.val;
            r5_sq         <= r4_sq;
        end
    end

    // ------------------------------------------------------------ square root
    logic [WORD_W-1:0] sq_root;
    t_side1 d1_side [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] d1_valid;

    dsi_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (r5_sq),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            d1_side[0] <= r5_side;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                d1_side[k] <= d1_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------ stage A
    // length clamp, stretch and unit vector dividends
    t_side1 s1o;
    logic [WORD_W-1:0] nA_len, nA_mx, nA_my;
    t_clip cA_st;
    logic  rA_valid;
    t_side2 rA_side;
    logic [DIV_N-1:0] rA_dvdx, rA_dvdy;

    always_comb begin
        s1o    = d1_side[SQRT_STAGES-1];
        nA_len = (sq_root == '0) ? WORD_W'(1) : sq_root;
        nA_mx  = s1o.dx[WORD_W-1] ? WORD_W'(-s1o.dx) : WORD_W'(s1o.dx);
        nA_my  = s1o.dy[WORD_W-1] ? WORD_W'(-s1o.dy) : WORD_W'(s1o.dy);
        cA_st  = clip_word(t_wide'($signed({1'b0, nA_len})) - t_wide'($signed({1'b0, r_rest})));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rA_side.pa      <= s1o.pa;
            rA_side.pb      <= s1o.pb;
            rA_side.sat     <= s1o.sat | cA_st.sat;
            rA_side.degen   <= s1o.degen;
            rA_side.sx      <= s1o.dx[WORD_W-1];
            rA_side.sy      <= s1o.dy[WORD_W-1];
            rA_side.g       <= s1o.g;
            rA_side.stretch <= cA_st.val;
            rA_side.len     <= nA_len;
            rA_dvdx         <= {nA_mx, {FRAC_W{1'b0}}};
            rA_dvdy         <= {nA_my, {FRAC_W{1'b0}}};
        end
    end

    // ------------------------------------------------------------ unit vector divide
    logic [DIV_N-1:0] qx, qy;
    t_side2 d2_side [DIV_STAGES];
    logic [DIV_STAGES-1:0] d2_valid;

    dsi_div u_div_ux (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (rA_dvdx),
        .i_divisor  (rA_side.len),
        .o_quotient (qx)
    );

    dsi_div u_div_uy (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (rA_dvdy),
        .i_divisor  (rA_side.len),
        .o_quotient (qy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            d2_side[0] <= rA_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                d2_side[k] <= d2_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------ stage B
    // signed unit vector, stiffness times stretch
    t_side2 s2o;
    t_unit nB_mx, nB_my, nB_ux, nB_uy;
    t_prod nB_pst;
    logic  rB_valid, rB_pa, rB_pb, rB_sat, rB_degen;
    t_unit rB_ux, rB_uy;
    t_prod rB_pst;
    t_word rB_g;
    logic [WORD_W-1:0] rB_len;

    always_comb begin
        s2o    = d2_side[DIV_STAGES-1];
        nB_mx  = $signed({1'b0, qx[FRAC_W:0]});
        nB_my  = $signed({1'b0, qy[FRAC_W:0]});
        nB_ux  = s2o.sx ? -nB_mx : nB_mx;
        nB_uy  = s2o.sy ? -nB_my : nB_my;
        nB_pst = $signed({1'b0, r_stiff}) * s2o.stretch;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rB_pa    <= s2o.pa;
            rB_pb    <= s2o.pb;
            rB_sat   <= s2o.sat;
            rB_degen <= s2o.degen;
            rB_ux    <= nB_ux;
            rB_uy    <= nB_uy;
            rB_pst   <= nB_pst;
            rB_g     <= s2o.g;
            rB_len   <= s2o.len;
        end
    end

    // ------------------------------------------------------------ stage C
    // spring term s and damping products g*u
    t_clip cC_s;
    t_gu   nC_gux, nC_guy;
    logic  rC_valid, rC_pa, rC_pb, rC_sat, rC_degen;
    t_word rC_s;
    t_unit rC_ux, rC_uy;
    t_gu   rC_gux, rC_guy;
    logic [WORD_W-1:0] rC_len;

    always_comb begin
        cC_s   = clip_word(t_wide'(rB_pst >>> FRAC_W));
        nC_gux = rB_g * rB_ux;
        nC_guy = rB_g * rB_uy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rC_pa    <= rB_pa;
            rC_pb    <= rB_pb;
            rC_sat   <= rB_sat | cC_s.sat;
            rC_degen <= rB_degen;
            rC_s     <= cC_s.val;
            rC_ux    <= rB_ux;
            rC_uy    <= rB_uy;
            rC_gux   <= nC_gux;
            rC_guy   <= nC_guy;
            rC_len   <= rB_len;
        end
    end

    // ------------------------------------------------------------ stage D
    // spring products s*u and damping dividend magnitudes
    t_gu   nD_sux, nD_suy, nD_gax, nD_gay;
    logic  rD_valid;
    t_side3 rD_side;
    logic [DIV_N-1:0] rD_gmx, rD_gmy;
    logic [WORD_W-1:0] rD_len;

    always_comb begin
        nD_sux = rC_s * rC_ux;
        nD_suy = rC_s * rC_uy;
        nD_gax = rC_gux[GU_W-1] ? -rC_gux : rC_gux;
        nD_gay = rC_guy[GU_W-1] ? -rC_guy : rC_guy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rD_side.pa    <= rC_pa;
            rD_side.pb    <= rC_pb;
            rD_side.sat   <= rC_sat;
            rD_side.degen <= rC_degen;
            rD_side.sgx   <= rC_gux[GU_W-1];
            rD_side.sgy   <= rC_guy[GU_W-1];
            rD_side.sux   <= nD_sux;
            rD_side.suy   <= nD_suy;
            rD_gmx        <= nD_gax[DIV_N-1:0];
            rD_gmy        <= nD_gay[DIV_N-1:0];
            rD_len        <= rC_len;
        end
    end

    // ------------------------------------------------------------ damping divide
    logic [DIV_N-1:0] q2x, q2y;
    t_side3 d3_side [DIV_STAGES];
    logic [DIV_STAGES-1:0] d3_valid;

    dsi_div u_div_gx (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (rD_gmx),
        .i_divisor  (rD_len),
        .o_quotient (q2x)
    );

    dsi_div u_div_gy (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (rD_gmy),
        .i_divisor  (rD_len),
        .o_quotient (q2y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            d3_side[0] <= rD_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                d3_side[k] <= d3_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------ stage E
    // impulse on A
    t_side3 s3o;
    t_wide nE_qx, nE_qy;
    t_clip cE_ix, cE_iy;
    logic  rE_valid, rE_pa, rE_pb, rE_sat, rE_degen;
    t_word rE_ix, rE_iy;

    always_comb begin
        s3o   = d3_side[DIV_STAGES-1];
        nE_qx = t_wide'($signed({1'b0, q2x}));
        nE_qy = t_wide'($signed({1'b0, q2y}));
        if (s3o.sgx) begin
            nE_qx = -nE_qx;
        end
        if (s3o.sgy) begin
            nE_qy = -nE_qy;
        end
        cE_ix = clip_word(t_wide'(s3o.sux >>> FRAC_W) + nE_qx);
        cE_iy = clip_word(t_wide'(s3o.suy >>> FRAC_W) + nE_qy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rE_pa    <= s3o.pa;
            rE_pb    <= s3o.pb;
            rE_sat   <= s3o.sat | cE_ix.sat | cE_iy.sat;
            rE_degen <= s3o.degen;
            rE_ix    <= cE_ix.val;
            rE_iy    <= cE_iy.val;
        end
    end

    // ------------------------------------------------------------ output register
    // negated impulse on B, degenerate override
    t_clip cF_bx, cF_by;
    t_word r_out_ax, r_out_ay, r_out_bx, r_out_by;
    logic  r_out_pa, r_out_pb, r_out_degen, r_out_sat;

    always_comb begin
        cF_bx = clip_word(-t_wide'(rE_ix));
        cF_by = clip_word(-t_wide'(rE_iy));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_ax    <= rE_degen ? t_word'(0) : rE_ix;
            r_out_ay    <= rE_degen ? t_word'(0) : rE_iy;
            r_out_bx    <= rE_degen ? t_word'(0) : cF_bx.val;
            r_out_by    <= rE_degen ? t_word'(0) : cF_by.val;
            r_out_pa    <= rE_pa;
            r_out_pb    <= rE_pb;
            r_out_degen <= rE_degen;
            r_out_sat   <= !rE_degen && (rE_sat | cF_bx.sat | cF_by.sat);
        end
    end

    // ------------------------------------------------------------ valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            d1_valid    <= '0;
            rA_valid    <= 1'b0;
            d2_valid    <= '0;
            rB_valid    <= 1'b0;
            rC_valid    <= 1'b0;
            rD_valid    <= 1'b0;
            d3_valid    <= '0;
            rE_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_valid && (i_body_a_present || i_body_b_present);
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            d1_valid    <= {d1_valid[SQRT_STAGES-2:0], r5_valid};
            rA_valid    <= d1_valid[SQRT_STAGES-1];
            d2_valid    <= {d2_valid[DIV_STAGES-2:0], rA_valid};
            rB_valid    <= d2_valid[DIV_STAGES-1];
            rC_valid    <= rB_valid;
            rD_valid    <= rC_valid;
            d3_valid    <= {d3_valid[DIV_STAGES-2:0], rD_valid};
            rE_valid    <= d3_valid[DIV_STAGES-1];
            r_out_valid <= rE_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_impulse_a_x = r_out_ax;
    assign o_impulse_a_y = r_out_ay;
    assign o_impulse_b_x = r_out_bx;
    assign o_impulse_b_y = r_out_by;
    assign o_apply_a     = r_out_pa;
    assign o_apply_b     = r_out_pb;
    assign o_degenerate  = r_out_degen;
    assign o_saturated   = r_out_sat;

`ifndef SYNTHESIS
    // degenerate results carry zero impulses and no saturation
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_impulse_a_x == t_word'(0) &&
        o_impulse_a_y == t_word'(0) && o_impulse_b_x == t_word'(0) &&
        o_impulse_b_y == t_word'(0) && !o_saturated)
        else $error("degenerate result with nonzero impulse or saturation");

    // a result always names at least one present body
    a_some_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_apply_a || o_apply_b)
        else $error("result delivered with neither body present");

    // backpressure only while a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // impulse on B is the negation of A unless clipped
    a_negate_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_impulse_a_x != WORD_MIN |-> o_impulse_b_x == -o_impulse_a_x)
        else $error("impulse B x is not the negation of impulse A x");
`endif

endmodule
